// File: rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants and types of the first-fit bank allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int NUM_BANKS  = 64;
  localparam int BANK_BYTES = 2048 * 64;
  localparam int OWNER_BITS = 8;

  // Fixed field widths of the request and result channels
  localparam int MODE_W   = 1;
  localparam int OWNER_W  = 8;
  localparam int SIZE_W   = 24;
  localparam int START_W  = 6;

  localparam int IDX_W    = $clog2(NUM_BANKS);
  // Width of the byte count covered by a run of every bank
  localparam int RUN_W    = $clog2(NUM_BANKS * BANK_BYTES + 1);
  localparam int CMP_W    = (RUN_W > SIZE_W) ? RUN_W : SIZE_W;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

  // Contents of one bank cell
  typedef struct packed {
    logic                  busy;
    logic                  tent;
    logic [OWNER_BITS-1:0] owner;
  } bank_t;

  // Controls broadcast to every cell
  typedef struct packed {
    logic                  shift;
    logic                  clr_tent;
    logic                  commit;
    logic                  keep;
    logic [OWNER_BITS-1:0] owner;
  } cell_ctrl_t;

endpackage

// File: rtl/ffba_if.sv
// ----------------------------------------------------------------------------
// ffba_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface ffba_req_if;
  logic                         valid;
  logic                         ready;
  logic [ffba_pkg::MODE_W-1:0]  mode;
  logic [ffba_pkg::OWNER_W-1:0] owner_id;
  logic [ffba_pkg::SIZE_W-1:0]  size_bytes;

  modport source (output valid, output mode, output owner_id, output size_bytes,
                  input ready);
  modport sink   (input valid, input mode, input owner_id, input size_bytes,
                  output ready);
endinterface

interface ffba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ffba_pkg::START_W-1:0] start_bank;
  logic                         granted;

  modport source (output valid, output start_bank, output granted, input ready);
  modport sink   (input valid, input start_bank, input granted, output ready);
endinterface

// File: rtl/first_fit_bank_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_bank_allocator
// Bank-granular first-fit allocator built as a rotating ring of bank cells.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                            | transaction
//  in_ch    | in  | mode, owner_id, size_bytes         | valid & ready
//  out_ch   | out | start_bank, granted                | valid & ready
//
//  Each request is accepted, then the ring rotates every bank past the head
//  scanner, then the tentative marks are committed and finally the result
//  register is loaded.
//  A new request is taken once the previous result is loaded; a stalled
//  result holds the next one in the result step only.
//  Synchronous reset frees every bank and clears every owner id.
// ----------------------------------------------------------------------------
module first_fit_bank_allocator (
  input  logic       clk,
  input  logic       rst_n,
  ffba_req_if.sink   in_ch,
  ffba_rsp_if.source out_ch
);
  import ffba_pkg::*;

  bank_t      bank_q [NUM_BANKS];
  bank_t      head_wr;
  cell_ctrl_t cell_ctrl;

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .head_in  (bank_q[0]),
    .head_out (head_wr),
    .ctrl     (cell_ctrl)
  );

  // Cell 0 is the head; its edited contents wrap to the tail
  for (genvar i = 0; i < NUM_BANKS; i++) begin : g_cell
    if (i == NUM_BANKS - 1) begin : g_tail
      ffba_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cell_ctrl),
        .bank_in  (head_wr),
        .bank_out (bank_q[i])
      );
    end else begin : g_body
      ffba_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cell_ctrl),
        .bank_in  (bank_q[i+1]),
        .bank_out (bank_q[i])
      );
    end
  end

endmodule

// File: rtl/ffba_cell.sv
// ----------------------------------------------------------------------------
// ffba_cell
// One bank of the ring: busy mark, tentative mark and owner id.
// ----------------------------------------------------------------------------
module ffba_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ffba_pkg::cell_ctrl_t ctrl,
  input  ffba_pkg::bank_t      bank_in,
  output ffba_pkg::bank_t      bank_out
);
  import ffba_pkg::*;

  bank_t bank_r;
  bank_t bank_nxt;

  always_comb begin
    bank_nxt = bank_r;
    if (ctrl.shift) begin
      bank_nxt      = bank_in;
      bank_nxt.tent = bank_in.tent & ~ctrl.clr_tent;
    end else if (ctrl.commit) begin
      // Promote a tentative bank to busy when the run was found
      if (bank_r.tent && ctrl.keep) begin
        bank_nxt.busy  = 1'b1;
        bank_nxt.owner = ctrl.owner;
      end
      bank_nxt.tent = 1'b0;
    end else if (ctrl.clr_tent) begin
      bank_nxt.tent = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= '0;
    end else begin
      bank_r <= bank_nxt;
    end
  end

  assign bank_out = bank_r;

endmodule

// File: rtl/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Request sequencer and head-of-ring scan logic.
// ----------------------------------------------------------------------------
module ffba_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  ffba_req_if.sink             in_ch,
  ffba_rsp_if.source           out_ch,
  input  ffba_pkg::bank_t      head_in,
  output ffba_pkg::bank_t      head_out,
  output ffba_pkg::cell_ctrl_t ctrl
);
  import ffba_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BANKS - 1);
  localparam logic [CMP_W-1:0] BANK_INC = CMP_W'(BANK_BYTES);

  logic [1:0]            state_r, state_nxt;
  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [OWNER_BITS-1:0] owner_r, owner_nxt;
  logic [CMP_W-1:0]      size_r, size_nxt;
  logic [CMP_W-1:0]      run_r, run_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0]      first_r, first_nxt;
  logic                  found_r, found_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [START_W-1:0]    start_r, start_nxt;
  logic                  granted_r, granted_nxt;
  logic                  accept;
  logic                  slot_free;

  assign accept    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    owner_nxt     = owner_r;
    size_nxt      = size_r;
    run_nxt       = run_r;
    idx_nxt       = idx_r;
    first_nxt     = first_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    start_nxt     = start_r;
    granted_nxt   = granted_r;
    head_out      = head_in;
    ctrl          = '0;
    ctrl.owner    = owner_r;
    ctrl.keep     = found_r && (mode_r == MODE_ALLOC);
    in_ch.ready   = (state_r == S_IDLE);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt  = in_ch.mode;
          owner_nxt = OWNER_BITS'(in_ch.owner_id);
          // A zero size takes one bank
          size_nxt  = (in_ch.size_bytes == '0) ? CMP_W'(1) : CMP_W'(in_ch.size_bytes);
          run_nxt   = '0;
          idx_nxt   = '0;
          first_nxt = '0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ctrl.shift = 1'b1;
        if (mode_r == MODE_FREE) begin
          if (head_in.busy && head_in.owner == owner_r) begin
            head_out.busy  = 1'b0;
            head_out.owner = '0;
          end
        end else if (!found_r) begin
          if (head_in.busy) begin
            // Run broken: drop every tentative mark
            ctrl.clr_tent = 1'b1;
            run_nxt       = '0;
          end else begin
            head_out.tent = 1'b1;
            run_nxt       = run_r + BANK_INC;
            if (run_r == '0) begin
              first_nxt = idx_r;
            end
            if (run_nxt >= size_r) begin
              found_nxt = 1'b1;
            end
          end
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        ctrl.commit = 1'b1;
        state_nxt   = S_RESULT;
      end
      S_RESULT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          granted_nxt   = (mode_r == MODE_FREE) || found_r;
          start_nxt     = (mode_r == MODE_ALLOC && found_r) ? START_W'(first_r) : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    owner_r   <= owner_nxt;
    size_r    <= size_nxt;
    run_r     <= run_nxt;
    idx_r     <= idx_nxt;
    first_r   <= first_nxt;
    found_r   <= found_nxt;
    start_r   <= start_nxt;
    granted_r <= granted_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.start_bank = start_r;
  assign out_ch.granted    = granted_r;

endmodule
